// File: rtl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [OPERAND_WIDTH:0]   wide_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    localparam cnt_t     CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);
    localparam operand_t ONE      = OPERAND_WIDTH'(1);

endpackage

// File: rtl/mexp_mulmod.sv
`timescale 1ns / 1ps

module mexp_mulmod (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mexp_pkg::operand_t a,
    input  mexp_pkg::operand_t b,
    input  mexp_pkg::operand_t m,
    output logic              done,
    output mexp_pkg::operand_t result
);
    import mexp_pkg::*;

    logic     busy_reg, busy_next;
    logic     phase_reg, phase_next;
    logic     done_reg, done_next;
    cnt_t     cnt_reg, cnt_next;
    operand_t acc_reg, acc_next;
    operand_t a_reg, a_next;
    operand_t bits_reg, bits_next;

    operand_t addend;
    wide_t    sum;
    wide_t    red;

    // one modular add per cycle: doubling phase, then conditional add of a
    always_comb
    begin
        addend = phase_reg ? (bits_reg[OPERAND_WIDTH-1] ? a_reg : '0) : acc_reg;
        sum    = {1'b0, acc_reg} + {1'b0, addend};
        if ((m != '0) && (sum >= {1'b0, m}))
        begin
            red = sum - {1'b0, m};
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        bits_next  = bits_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = '0;
            acc_next   = '0;
            a_next     = a;
            bits_next  = b;
        end
        else if (busy_reg)
        begin
            acc_next   = red[OPERAND_WIDTH-1:0];
            phase_next = !phase_reg;
            if (phase_reg)
            begin
                bits_next = {bits_reg[OPERAND_WIDTH-2:0], 1'b0};
                if (cnt_reg == CNT_LAST)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        bits_reg <= bits_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// File: rtl/modular_exponentiation_top.sv
`timescale 1ns / 1ps
// modular exponentiation: power_result = base_value ** exponent_value mod modulus
// input channel: in_valid / in_stall with base_value and exponent_value;
//   an item is taken when in_valid is high and in_stall is low
// output channel: out_valid / out_stall with power_result, one result per item
// config: modulus_wr_en writes modulus; write only while the block is idle
// the base is first reduced bit-serially (skipped for modulus 0),
//   then one exponent bit per round, lsb first, until no set bits remain
// each round runs the multiply and the squaring on two bit-serial modular
//   multipliers in parallel, a doubling phase and an add phase per multiplier bit
// one item is in work at a time
// in_stall is low only while no item is in work; a finished result waits in the
//   output register, so the next item is taken while out_stall holds it
// if the output register is still full when an item finishes, the block waits
// reset clears all control state and sets the modulus to 1; no result is valid
module modular_exponentiation_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               modulus_wr_en,
    input  mexp_pkg::operand_t modulus,
    input  logic               in_valid,
    output logic               in_stall,
    input  mexp_pkg::operand_t base_value,
    input  mexp_pkg::operand_t exponent_value,
    output logic               out_valid,
    input  logic               out_stall,
    output mexp_pkg::operand_t power_result
);
    import mexp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t   state_reg, state_next;
    operand_t modulus_reg;
    logic     out_valid_reg, out_valid_next;
    operand_t power_result_reg, power_result_next;
    cnt_t     cnt_reg, cnt_next;
    operand_t b_reg, b_next;
    operand_t e_reg, e_next;
    operand_t acc_reg, acc_next;
    operand_t rem_reg, rem_next;

    wide_t    rem_shift;
    wide_t    rem_red;
    logic     accept;
    logic     mul_start;
    logic     acc_done;
    logic     sq_done;
    operand_t acc_prod;
    operand_t sq_prod;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign mul_start = (state_reg == ST_CHECK) && (e_reg != '0);

    // restoring remainder, one base bit a cycle
    always_comb
    begin
        rem_shift = {rem_reg, b_reg[OPERAND_WIDTH-1]};
        if (rem_shift >= {1'b0, modulus_reg})
        begin
            rem_red = rem_shift - {1'b0, modulus_reg};
        end
        else
        begin
            rem_red = rem_shift;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        power_result_next = power_result_reg;
        cnt_next          = cnt_reg;
        b_next            = b_reg;
        e_next            = e_reg;
        acc_next          = acc_reg;
        rem_next          = rem_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    b_next   = base_value;
                    e_next   = exponent_value;
                    acc_next = ONE;
                    rem_next = '0;
                    cnt_next = '0;
                    if (modulus_reg == '0)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                rem_next = rem_red[OPERAND_WIDTH-1:0];
                b_next   = {b_reg[OPERAND_WIDTH-2:0], 1'b0};
                if (cnt_reg == CNT_LAST)
                begin
                    b_next     = rem_red[OPERAND_WIDTH-1:0];
                    state_next = ST_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_CHECK:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                if (sq_done)
                begin
                    if (e_reg[0])
                    begin
                        acc_next = acc_prod;
                    end
                    b_next     = sq_prod;
                    e_next     = {1'b0, e_reg[OPERAND_WIDTH-1:1]};
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    power_result_next = acc_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            modulus_reg   <= ONE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (modulus_wr_en)
            begin
                modulus_reg <= modulus;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        power_result_reg <= power_result_next;
        b_reg            <= b_next;
        e_reg            <= e_next;
        acc_reg          <= acc_next;
        rem_reg          <= rem_next;
    end

    // running product times base
    mexp_mulmod u_acc_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (acc_reg),
        .b      (b_reg),
        .m      (modulus_reg),
        .done   (acc_done),
        .result (acc_prod)
    );

    // base squared
    mexp_mulmod u_sq_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (b_reg),
        .b      (b_reg),
        .m      (modulus_reg),
        .done   (sq_done),
        .result (sq_prod)
    );

    assign out_valid    = out_valid_reg;
    assign power_result = power_result_reg;

    a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        acc_done == sq_done)
        else $error("multipliers out of step");

    a_mult_nonzero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MULT) |-> (e_reg != '0))
        else $error("multiply round with zero exponent");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_REDUCE) || (state_reg == ST_CHECK))
        else $error("accepted item did not start");

    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE) |-> (rem_reg < modulus_reg))
        else $error("remainder not reduced");

    a_done_in_mult: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == ST_MULT))
        else $error("multiplier done outside a round");

endmodule
